// File: hdl/extended_float_remainder_core_macros.svh
// Assertion macros for the extended float remainder core.
// Depends on a clk and an arst_n signal in the scope that uses them.
`ifndef EXTENDED_FLOAT_REMAINDER_CORE_MACROS_SVH
`define EXTENDED_FLOAT_REMAINDER_CORE_MACROS_SVH

// Antecedent holds in the same cycle as the consequent.
`define EFR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("efr assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define EFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("efr assertion failed");

`endif

// File: hdl/efr_pkg.sv
// Package for the extended float remainder core: widths, codes and payload types.
// Used by efr_datapath, efr_ctrl and extended_float_remainder_core; depends on nothing.
package efr_pkg;

	localparam int EXP_W  = 15;
	localparam int MANT_W = 64;
	// working exponent: covers 32767 down to about -130 as two's complement
	localparam int EXPI_W = 17;

	localparam logic [EXP_W-1:0]  EXP_MAX   = 15'h7fff;
	localparam logic [MANT_W-1:0] QNAN_MANT = 64'hC000_0000_0000_0000;

	typedef struct packed {
		logic              x_sign;
		logic [EXP_W-1:0]  x_exponent;
		logic [MANT_W-1:0] x_mantissa;
		logic              y_sign;
		logic [EXP_W-1:0]  y_exponent;
		logic [MANT_W-1:0] y_mantissa;
	} op_t;

	typedef struct packed {
		logic              rem_sign;
		logic [EXP_W-1:0]  rem_exponent;
		logic [MANT_W-1:0] rem_mantissa;
		logic              invalid;
	} rem_t;

	typedef enum logic [1:0] {
		RES_NAN,
		RES_PASSX,
		RES_ZERO,
		RES_CALC
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     norm;
		logic     reduce;
		logic     final_sub;
		logic     renorm;
		logic     denorm;
		res_sel_t res_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic invalid;
		logic pass_x;
		logic norm_done;
		logic less;
		logic same;
		logic exp_gt;
		logic ge;
		logic diff_zero;
		logic mant_top;
		logic exp_pos;
	} dp_stat_t;

endpackage

// File: hdl/efr_datapath.sv
// Datapath of the extended float remainder core: operand registers, shift-subtract unit.
// Depends on efr_pkg; driven by efr_ctrl through ctrl_cmd_t, reports through dp_stat_t.
module efr_datapath import efr_pkg::*; (
	input  logic      clk,
	input  op_t       op,
	input  ctrl_cmd_t cmd,
	output dp_stat_t  stat,
	output rem_t      res
);

	logic                     x_sign_q;
	logic [EXP_W-1:0]         x_exp_q;
	logic [MANT_W-1:0]        x_mant_q;
	logic signed [EXPI_W-1:0] ex_q;
	logic signed [EXPI_W-1:0] ey_q;
	logic [MANT_W-1:0]        mx_q;
	logic [MANT_W-1:0]        my_q;

	logic                     ge;
	logic [MANT_W-1:0]        diff;
	logic [MANT_W-1:0]        shift_sub;
	logic [MANT_W-1:0]        reduce_next;
	logic signed [EXPI_W-1:0] exp_max_w;

	assign exp_max_w = EXPI_W'(EXP_MAX);
	assign ge        = (mx_q >= my_q);
	assign diff      = mx_q - my_q;
	assign shift_sub = {mx_q[MANT_W-2:0], 1'b0} - my_q;

	always_comb begin
		if (ge) begin
			reduce_next = {diff[MANT_W-2:0], 1'b0};
		end else if (mx_q[MANT_W-1]) begin
			reduce_next = shift_sub;
		end else begin
			reduce_next = {mx_q[MANT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_sign_q <= op.x_sign;
			x_exp_q  <= op.x_exponent;
			x_mant_q <= op.x_mantissa;
			// a zero exponent reads as one
			ex_q     <= (op.x_exponent == '0) ? EXPI_W'(1) : EXPI_W'(op.x_exponent);
			ey_q     <= (op.y_exponent == '0) ? EXPI_W'(1) : EXPI_W'(op.y_exponent);
			mx_q     <= op.x_mantissa;
			my_q     <= op.y_mantissa;
		end else if (cmd.norm) begin
			if (!mx_q[MANT_W-1]) begin
				mx_q <= {mx_q[MANT_W-2:0], 1'b0};
				ex_q <= ex_q - EXPI_W'(1);
			end
			if (!my_q[MANT_W-1]) begin
				my_q <= {my_q[MANT_W-2:0], 1'b0};
				ey_q <= ey_q - EXPI_W'(1);
			end
		end else if (cmd.reduce) begin
			mx_q <= reduce_next;
			ex_q <= ex_q - EXPI_W'(1);
		end else if (cmd.final_sub) begin
			mx_q <= diff;
		end else if (cmd.renorm) begin
			mx_q <= {mx_q[MANT_W-2:0], 1'b0};
			ex_q <= ex_q - EXPI_W'(1);
		end else if (cmd.denorm) begin
			mx_q <= {1'b0, mx_q[MANT_W-1:1]};
			ex_q <= ex_q + EXPI_W'(1);
		end
	end

	// special-case checks are valid only before the normalising shift
	assign stat.invalid   = (my_q == '0) || ((ey_q == exp_max_w) && (my_q[MANT_W-2:0] != '0))
		|| (ex_q == exp_max_w);
	assign stat.pass_x    = (ey_q == exp_max_w) || (mx_q == '0);
	assign stat.norm_done = mx_q[MANT_W-1] & my_q[MANT_W-1];
	assign stat.less      = (ex_q < ey_q) || ((ex_q == ey_q) && (mx_q < my_q));
	assign stat.same      = (ex_q == ey_q) && (mx_q == my_q);
	assign stat.exp_gt    = (ex_q > ey_q);
	assign stat.ge        = ge;
	assign stat.diff_zero = ge && (diff == '0);
	assign stat.mant_top  = mx_q[MANT_W-1];
	assign stat.exp_pos   = (ex_q > EXPI_W'(0));

	always_comb begin
		case (cmd.res_sel)
			RES_NAN: begin
				res = '{rem_sign: 1'b1, rem_exponent: EXP_MAX, rem_mantissa: QNAN_MANT,
					invalid: 1'b1};
			end
			RES_PASSX: begin
				res = '{rem_sign: x_sign_q, rem_exponent: x_exp_q, rem_mantissa: x_mant_q,
					invalid: 1'b0};
			end
			RES_ZERO: begin
				res = '{rem_sign: x_sign_q, rem_exponent: '0, rem_mantissa: '0,
					invalid: 1'b0};
			end
			RES_CALC: begin
				// a cleared integer bit marks a denormalised result
				res = '{rem_sign: x_sign_q,
					rem_exponent: mx_q[MANT_W-1] ? ex_q[EXP_W-1:0] : '0,
					rem_mantissa: mx_q, invalid: 1'b0};
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

// File: hdl/efr_ctrl.sv
// Controller of the extended float remainder core: sequences check, normalise, compare,
// reduce, final subtract, renormalise, denormalise and hand-off steps. Depends on efr_pkg.
module efr_ctrl import efr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	output logic      op_ready,
	input  logic      out_free,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd,
	output logic      res_load
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_NORM,
		S_CMP,
		S_REDUCE,
		S_FINAL,
		S_RENORM,
		S_DENORM,
		S_DONE
	} state_t;

	state_t   state_q;
	res_sel_t sel_q;

	assign op_ready = (state_q == S_IDLE);

	// the result register is written in the hand-off cycle
	assign res_load = (state_q == S_DONE) && out_free;

	always_comb begin
		cmd           = '0;
		cmd.res_sel   = sel_q;
		cmd.load      = (state_q == S_IDLE) && op_valid;
		cmd.norm      = (state_q == S_NORM) && !stat.norm_done;
		cmd.reduce    = (state_q == S_REDUCE) && stat.exp_gt && !stat.diff_zero;
		cmd.final_sub = (state_q == S_FINAL) && stat.ge && !stat.diff_zero;
		cmd.renorm    = (state_q == S_RENORM) && !stat.mant_top;
		cmd.denorm    = (state_q == S_DENORM) && !stat.exp_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= RES_NAN;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (op_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (stat.invalid) begin
						sel_q   <= RES_NAN;
						state_q <= S_DONE;
					end else if (stat.pass_x) begin
						sel_q   <= RES_PASSX;
						state_q <= S_DONE;
					end else begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (stat.norm_done) state_q <= S_CMP;
				end
				S_CMP: begin
					if (stat.less) begin
						sel_q   <= RES_PASSX;
						state_q <= S_DONE;
					end else if (stat.same) begin
						sel_q   <= RES_ZERO;
						state_q <= S_DONE;
					end else begin
						state_q <= S_REDUCE;
					end
				end
				S_REDUCE: begin
					if (!stat.exp_gt) begin
						state_q <= S_FINAL;
					end else if (stat.diff_zero) begin
						sel_q   <= RES_ZERO;
						state_q <= S_DONE;
					end
				end
				S_FINAL: begin
					if (stat.diff_zero) begin
						sel_q   <= RES_ZERO;
						state_q <= S_DONE;
					end else begin
						state_q <= S_RENORM;
					end
				end
				S_RENORM: begin
					if (stat.mant_top) begin
						if (stat.exp_pos) begin
							sel_q   <= RES_CALC;
							state_q <= S_DONE;
						end else begin
							state_q <= S_DENORM;
						end
					end
				end
				S_DENORM: begin
					if (stat.exp_pos) begin
						sel_q   <= RES_CALC;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/extended_float_remainder_core.sv
// Extended float remainder core: 80-bit x87 fmod, x - trunc(x/y)*y with the sign of x.
// Top level; depends on efr_pkg, efr_ctrl, efr_datapath and the assertion macros header.
//
// Usage:
//  - Operand channel op_valid/op_ready/op_data (op_t) takes one x, y pair per transaction;
//    the result channel rem_valid/rem_ready/rem_data (rem_t) returns exactly one result.
//  - One transaction is worked at a time. From the accepting edge to rem_valid it goes
//    through check, normalise (one bit a cycle on both operands at once), compare,
//    reduce (one step per unit of exponent difference d, d at most 32828), final
//    subtract, renormalise, denormalise and hand-off. Special cases (invalid operands,
//    infinite y, zero x) go from the check straight to the hand-off.
//  - The shared 64-bit shift-subtract unit in the datapath sets the rate: the reduce
//    loop takes one exponent step per cycle.
//  - The result sits in an output register; op_ready returns as soon as the result is
//    handed to it, so the next operands may be accepted while the receiver stalls.
//    A finished result with the output register still full waits in the hand-off state.
//  - Reset (arst_n low) drops any transaction in flight and clears rem_valid.
//  - Invalid operands give the default quiet NaN with invalid raised.
//
module extended_float_remainder_core import efr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_ready,
	input  op_t  op_data,
	output logic rem_valid,
	input  logic rem_ready,
	output rem_t rem_data
);

`include "extended_float_remainder_core_macros.svh"

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	rem_t      res;
	rem_t      rem_q;
	logic      rem_valid_q;
	logic      out_free;
	logic      res_load;

	// output register is free when empty or being drained this cycle
	assign out_free = !rem_valid_q || rem_ready;

	efr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd),
		.res_load (res_load)
	);

	efr_datapath u_datapath (
		.clk  (clk),
		.op   (op_data),
		.cmd  (cmd),
		.stat (stat),
		.res  (res)
	);

	// hold the result until the receiver takes it; refill in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_valid_q <= 1'b0;
		end else if (res_load) begin
			rem_valid_q <= 1'b1;
		end else if (rem_ready) begin
			rem_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) rem_q <= res;
	end

	assign rem_valid = rem_valid_q;
	assign rem_data  = rem_q;

	`EFR_ASSERT_NEXT(a_one_at_a_time, op_valid && op_ready, !op_ready)
	`EFR_ASSERT_SAME(a_nan_form, rem_valid && rem_data.invalid,
		rem_data.rem_sign && (rem_data.rem_exponent == EXP_MAX))
	`EFR_ASSERT_SAME(a_no_overwrite, rem_valid_q && !rem_ready, !res_load)

endmodule

// File: tb/efr_remainder_checker.sv
// Result checker for the extended float remainder core: predicts each remainder and compares.
// Watches the operand and result channels; depends on efr_pkg for the payload types.
module efr_remainder_checker import efr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	input  logic op_ready,
	input  op_t  op_data,
	input  logic rem_valid,
	input  logic rem_ready,
	input  rem_t rem_data,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	rem_t expected_rems[$];
	int   misses  = 0;
	int   waiting = 0;

	assign mismatches  = misses;
	assign outstanding = waiting;

	// Truncated remainder x - trunc(x/y)*y, sign of x, default NaN on invalid operands.
	function automatic rem_t remainder_of(input op_t op);
		rem_t        r;
		int          ex, ey, sh;
		logic [63:0] mx, my, d;
		r.rem_sign     = op.x_sign;
		r.rem_exponent = op.x_exponent;
		r.rem_mantissa = op.x_mantissa;
		r.invalid      = 1'b0;
		if (op.y_mantissa == '0 || op.x_exponent == EXP_MAX ||
				(op.y_exponent == EXP_MAX && op.y_mantissa[62:0] != '0)) begin
			r.rem_sign     = 1'b1;
			r.rem_exponent = EXP_MAX;
			r.rem_mantissa = QNAN_MANT;
			r.invalid      = 1'b1;
			return r;
		end
		if (op.y_exponent == EXP_MAX || op.x_mantissa == '0)
			return r;
		// normalise both operands; exponent 0 counts as 1
		ex = (op.x_exponent == '0) ? 1 : op.x_exponent;
		ey = (op.y_exponent == '0) ? 1 : op.y_exponent;
		mx = op.x_mantissa;
		my = op.y_mantissa;
		while (!mx[63]) begin
			mx = mx << 1;
			ex--;
		end
		while (!my[63]) begin
			my = my << 1;
			ey--;
		end
		if (ex < ey || (ex == ey && mx < my))
			return r;
		r.rem_exponent = '0;
		r.rem_mantissa = '0;
		if (ex == ey && mx == my)
			return r;
		// one shift-subtract step per unit of exponent difference
		for (; ex > ey; ex--) begin
			d = mx - my;
			if (mx >= my) begin
				if (d == '0)
					return r;
				mx = d << 1;
			end else if (mx[63]) begin
				mx = (mx << 1) - my;
			end else begin
				mx = mx << 1;
			end
		end
		if (mx >= my) begin
			d = mx - my;
			if (d == '0)
				return r;
			mx = d;
		end
		while (!mx[63]) begin
			mx = mx << 1;
			ex--;
		end
		if (ex <= 0) begin
			sh = 1 - ex;
			r.rem_mantissa = (sh >= 64) ? '0 : (mx >> sh);
			return r;
		end
		r.rem_exponent = ex[EXP_W-1:0];
		r.rem_mantissa = mx;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			misses++;
		end
	endtask

	always @(posedge clk) begin
		rem_t want;
		if (arst_n) begin
			if (rem_valid && rem_ready) begin
				if (expected_rems.size() == 0) begin
					$display("%0t: result with nothing outstanding, expected none got %h",
						$time, rem_data);
					misses++;
				end else begin
					want = expected_rems.pop_front();
					compare_field("rem_sign", 64'(want.rem_sign),
						64'(rem_data.rem_sign));
					compare_field("rem_exponent", 64'(want.rem_exponent),
						64'(rem_data.rem_exponent));
					compare_field("rem_mantissa", want.rem_mantissa,
						rem_data.rem_mantissa);
					compare_field("invalid", 64'(want.invalid),
						64'(rem_data.invalid));
				end
			end
			if (op_valid && op_ready)
				expected_rems.push_back(remainder_of(op_data));
		end
		waiting <= expected_rems.size();
	end

endmodule

// File: tb/extended_float_remainder_core_tb.sv
// Testbench top for the extended float remainder core: clock, reset, stimulus and verdict.
// Depends on efr_pkg, extended_float_remainder_core and efr_remainder_checker.
module extended_float_remainder_core_tb import efr_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM      = 80;
	localparam int IDLE_PCT      = 14;
	// transaction counts bounding the stretch where neither side idles
	localparam int QUIET_FROM    = 45;
	localparam int QUIET_TO      = 75;
	// receiver hold-off, long enough for the core to fill up and drop op_ready
	localparam int HOLD_AT       = 35;
	localparam int HOLD_CYCLES   = 3000;
	// random transaction after which the sender drains the core completely
	localparam int DRAIN_AT      = 70;
	// wide exponent spreads cost one reduction step per unit of spread, so keep them rare
	localparam int BIG_LIMIT     = 4;
	localparam int SETTLE_CYCLES = 300;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic op_valid  = 1'b0;
	logic op_ready;
	op_t  op_data   = '0;
	logic rem_valid;
	logic rem_ready = 1'b0;
	rem_t rem_data;
	int   mismatches;
	int   outstanding;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	extended_float_remainder_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op_data   (op_data),
		.rem_valid (rem_valid),
		.rem_ready (rem_ready),
		.rem_data  (rem_data)
	);

	efr_remainder_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (op_valid),
		.op_ready    (op_ready),
		.op_data     (op_data),
		.rem_valid   (rem_valid),
		.rem_ready   (rem_ready),
		.rem_data    (rem_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Offer one operand pair and hold it until the core takes it. Drop valid for a
	// random gap first unless the steady flag is set; otherwise keep valid high and
	// just swap the payload, so the sender adds no idle gap between back-to-back transactions.
	task automatic offer_operands(input op_t v, input bit steady);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			op_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		op_valid <= 1'b1;
		op_data  <= v;
		do @(posedge clk); while (!op_ready);
	endtask

	// Withdraw valid and wait until every expected result has come back.
	// The extra edge lets the checker count the last transaction first.
	task automatic drain_results();
		op_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Result side: random stalls, one long hold-off, and a stretch that never stalls.
	initial begin : result_sink
		int seen;
		int hold_left;
		bit held;
		seen      = 0;
		hold_left = 0;
		held      = 1'b0;
		forever begin
			@(posedge clk);
			if (op_valid && op_ready)
				seen++;
			if (!held && seen >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rem_ready <= 1'b0;
			end else if (seen >= QUIET_FROM && seen < QUIET_TO) begin
				rem_ready <= 1'b1;
			end else begin
				rem_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin : operand_source
		op_t trial_ops[$];
		op_t op;
		int  sent;
		int  r;
		int  gap;
		int  big_left;

		// Directed operands: sign, exponent, mantissa of x, then of y.
		// invalid: zero divisor, zero divisor with large exponent, NaN divisor,
		// pseudo-NaN divisor, infinite dividend, NaN dividend
		trial_ops.push_back('{1'b0, 15'h3fff, 64'h8000_0000_0000_0000,
			1'b0, 15'h3fff, 64'h0});
		trial_ops.push_back('{1'b1, 15'h0001, 64'hffff_ffff_ffff_ffff,
			1'b1, 15'h7ffe, 64'h0});
		trial_ops.push_back('{1'b0, 15'h4000, 64'hc000_0000_0000_0000,
			1'b0, 15'h7fff, 64'hc000_0000_0000_0001});
		trial_ops.push_back('{1'b0, 15'h4000, 64'hc000_0000_0000_0000,
			1'b1, 15'h7fff, 64'h0000_0000_0000_0001});
		trial_ops.push_back('{1'b1, 15'h7fff, 64'h8000_0000_0000_0000,
			1'b0, 15'h3fff, 64'h8000_0000_0000_0000});
		trial_ops.push_back('{1'b0, 15'h7fff, 64'hffff_ffff_ffff_ffff,
			1'b0, 15'h7fff, 64'h8000_0000_0000_0000});
		// infinite divisor hands back a finite x untouched
		trial_ops.push_back('{1'b1, 15'h7ffe, 64'hffff_ffff_ffff_ffff,
			1'b0, 15'h7fff, 64'h8000_0000_0000_0000});
		// zero dividend, with and without an exponent
		trial_ops.push_back('{1'b1, 15'h1234, 64'h0,
			1'b0, 15'h3fff, 64'h8000_0000_0000_0000});
		trial_ops.push_back('{1'b0, 15'h0000, 64'h0,
			1'b1, 15'h0000, 64'h0000_0000_0000_0001});
		// dividend smaller by mantissa, then by exponent
		trial_ops.push_back('{1'b0, 15'h3fff, 64'h8000_0000_0000_0000,
			1'b0, 15'h3fff, 64'hc000_0000_0000_0000});
		trial_ops.push_back('{1'b1, 15'h0000, 64'h0000_0000_0000_0001,
			1'b0, 15'h7ffe, 64'hffff_ffff_ffff_ffff});
		// equal magnitudes of opposite sign
		trial_ops.push_back('{1'b1, 15'h4000, 64'ha5a5_a5a5_a5a5_a5a5,
			1'b0, 15'h4000, 64'ha5a5_a5a5_a5a5_a5a5});
		// exact multiple: a reduction step leaves zero
		trial_ops.push_back('{1'b0, 15'h4003, 64'hc000_0000_0000_0000,
			1'b1, 15'h4000, 64'hc000_0000_0000_0000});
		// unnormal x equal to a normal y once normalised
		trial_ops.push_back('{1'b1, 15'h0002, 64'h4000_0000_0000_0000,
			1'b0, 15'h0001, 64'h8000_0000_0000_0000});
		// subnormal result, and both operands subnormal
		trial_ops.push_back('{1'b0, 15'h0001, 64'hffff_ffff_ffff_ffff,
			1'b0, 15'h0000, 64'h0000_0000_0000_0003});
		trial_ops.push_back('{1'b1, 15'h0000, 64'h7fff_ffff_ffff_ffff,
			1'b0, 15'h0000, 64'h0000_0000_1234_5679});
		// unnormal dividend with an ordinary divisor
		trial_ops.push_back('{1'b0, 15'h4010, 64'h0000_0001_2345_6789,
			1'b0, 15'h3ff0, 64'h8765_4321_0fed_cba9});
		// largest finite exponents on both sides
		trial_ops.push_back('{1'b0, 15'h7ffe, 64'hffff_ffff_ffff_ffff,
			1'b1, 15'h7ffe, 64'h8000_0000_0000_0001});
		// widest exponent spread: largest x over the smallest subnormal y
		trial_ops.push_back('{1'b0, 15'h7ffe, 64'hffff_ffff_ffff_ffff,
			1'b1, 15'h0000, 64'h0000_0000_0000_0001});
		trial_ops.push_back('{1'b1, 15'h4040, 64'h8000_0000_0000_0000,
			1'b0, 15'h4000, 64'hffff_ffff_ffff_ffff});

		// hold reset low at the start; release it with a clock edge so nothing races
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sent = 0;
		foreach (trial_ops[i]) begin
			offer_operands(trial_ops[i], 1'b0);
			sent++;
		end
		// pause the sender until the core and the result side are empty
		drain_results();

		big_left = BIG_LIMIT;
		for (int n = 0; n < N_RANDOM; n++) begin
			op = {$urandom, $urandom, $urandom, $urandom, $urandom};
			r  = $urandom_range(0, 99);
			if (r < 6) begin
				// special operands: all are settled at the check and go straight to hand-off
				case ($urandom_range(0, 4))
					0: op.y_mantissa = '0;
					1: begin
						op.y_exponent     = EXP_MAX;
						op.y_mantissa[0]  = 1'b1;
					end
					2: op.x_exponent = EXP_MAX;
					3: begin
						op.y_exponent = EXP_MAX;
						op.y_mantissa = 64'h8000_0000_0000_0000;
					end
					default: op.x_mantissa = '0;
				endcase
			end else if (r < 9 && big_left > 0) begin
				// anything goes on the exponents: possibly a very long reduction
				big_left--;
				op.x_exponent = EXP_W'($urandom_range(0, 32766));
				op.y_exponent = EXP_W'($urandom_range(0, 32766));
			end else if (r < 22) begin
				// subnormal and unnormal territory near the bottom of the range
				op.x_exponent = EXP_W'($urandom_range(0, 2));
				op.y_exponent = EXP_W'($urandom_range(0, 1));
				op.x_mantissa = op.x_mantissa >> $urandom_range(0, 63);
				op.y_mantissa = op.y_mantissa >> $urandom_range(0, 63);
			end else if (r < 30) begin
				// divisor at or above the dividend: mostly x comes back as is
				op.x_exponent    = EXP_W'($urandom_range(0, 32760));
				op.y_exponent    = EXP_W'(op.x_exponent + $urandom_range(0, 2));
				op.x_mantissa[63] = 1'b1;
				op.y_mantissa[63] = 1'b1;
			end else if (r < 36) begin
				// x a power-of-two multiple of y: remainder is a signed zero
				op.x_exponent     = EXP_W'($urandom_range(70, 32766));
				op.x_mantissa[63] = 1'b1;
				op.y_mantissa     = op.x_mantissa;
				op.y_exponent     = EXP_W'(op.x_exponent - $urandom_range(0, 6));
			end else begin
				// ordinary case: short reduction anywhere in the exponent range
				gap           = $urandom_range(0, 70);
				op.x_exponent = EXP_W'($urandom_range(1, 32766));
				op.y_exponent = EXP_W'((op.x_exponent > gap) ? op.x_exponent - gap
					: $urandom_range(0, 1));
				if ($urandom_range(0, 99) < 85)
					op.x_mantissa[63] = 1'b1;
				if ($urandom_range(0, 99) < 85)
					op.y_mantissa[63] = 1'b1;
			end
			// outside the special cases a zero divisor would only mask the datapath
			if (r >= 6 && op.y_mantissa == '0)
				op.y_mantissa = 64'h1;
			offer_operands(op, sent >= QUIET_FROM && sent < QUIET_TO);
			sent++;
			if (n == DRAIN_AT)
				drain_results();
		end

		drain_results();
		// let any stray result surface before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, including every wide spread.
	initial begin : watchdog
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
